>>> sv/gdo_pkg.sv
package gdo_pkg;

   // Node numbers and the configuration port are fixed in width.
   localparam int NODE_W = 6;
   localparam int CNT_W  = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_NODES   = 64;
   localparam int DEF_STACK_DEPTH = 4096;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTED   = 1'd1;

   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   // Operation codes of an input word.
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_RUN      = 1'b1;

   typedef struct packed {
      logic              op;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] visit_node;
      logic              last;
   } rsp_type;

endpackage

>>> sv/graph_dfs_order_core.sv
// Depth-first visiting order of a small graph held as an adjacency bit matrix in a
// MAX_NODES x MAX_NODES RAM. An add-edge word reads and writes back the from-node row,
// and the to-node row too when the edge is mirrored, each touched row going through
// the single RAM port pair. The first run word walks the graph from node 0 with a
// stack kept in a STACK_DEPTH-entry RAM: each pop reads the stack, and each newly
// visited node has its row read and shifted out one bit a cycle up to its highest
// unvisited neighbour, to push neighbours in ascending order. The order is stored as
// nodes are visited, and every run, the first included, replays it one result word
// at a time, holding while rsp_stall is high. Input words are taken only while the
// block is idle. Adjacency rows carry valid bits cleared by reset, so there is no
// clearing pass.
module graph_dfs_order_core #(
   parameter int MAX_NODES   = gdo_pkg::DEF_MAX_NODES,
   parameter int STACK_DEPTH = gdo_pkg::DEF_STACK_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gdo_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gdo_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [gdo_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gdo_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NW   = gdo_pkg::NODE_W;
   localparam int CW   = gdo_pkg::CNT_W;
   localparam int RAW  = $clog2(MAX_NODES);
   localparam int SAW  = $clog2(STACK_DEPTH);
   localparam int SPW  = $clog2(STACK_DEPTH + 1);
   localparam int LENW = $clog2(MAX_NODES + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_START,
      ST_POP,
      ST_POP_WAIT,
      ST_ROW_WAIT,
      ST_PUSH,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         node_count_ff;
   logic                  directed_ff;
   logic [MAX_NODES-1:0]  row_valid_ff;
   logic [MAX_NODES-1:0]  visited_ff;
   logic [MAX_NODES-1:0]  scan_ff;
   logic [MAX_NODES-1:0]  mask_ff;
   logic [NW-1:0]         scan_idx_ff;
   logic [SPW-1:0]        sp_ff;
   logic [LENW-1:0]       len_ff;
   logic [LENW-1:0]       emit_idx_ff;
   logic                  order_ready_ff;
   logic [NW-1:0]         node_a_ff;
   logic [NW-1:0]         node_b_ff;
   logic                  mirror_ff;
   logic [RAW-1:0]        adj_raddr_ff;
   logic                  rsp_valid_ff;
   gdo_pkg::rsp_type      rsp_data_ff;

   logic [CW-1:0]         live_n;
   logic [MAX_NODES-1:0]  live_mask;
   logic                  req_take;
   logic                  edge_ok;

   logic                  adj_we;
   logic [RAW-1:0]        adj_waddr;
   logic [MAX_NODES-1:0]  adj_wdata;
   logic                  adj_re;
   logic [RAW-1:0]        adj_raddr;
   logic [MAX_NODES-1:0]  adj_rdata;
   logic [MAX_NODES-1:0]  adj_row;

   logic                  stk_we;
   logic [SAW-1:0]        stk_waddr;
   logic [NW-1:0]         stk_wdata;
   logic                  stk_re;
   logic [SAW-1:0]        stk_raddr;
   logic [NW-1:0]         stk_rdata;

   logic                  ord_we;
   logic                  ord_re;
   logic [NW-1:0]         ord_rdata;

   logic                  pop_fresh;
   logic                  push_now;
   logic                  emit_go;

   // Node count in use: capped at MAX_NODES, and zero counts as one.
   always_comb begin
      if (node_count_ff > CW'(MAX_NODES)) begin
         live_n = CW'(MAX_NODES);
      end else if (node_count_ff == '0) begin
         live_n = CW'(1);
      end else begin
         live_n = node_count_ff;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         live_mask[i] = (CW'(i) < live_n);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign edge_ok   = (req_data.from_node != req_data.to_node)
                   && ({1'b0, req_data.from_node} < live_n)
                   && ({1'b0, req_data.to_node} < live_n);

   // A row that was never written reads as empty.
   assign adj_row   = row_valid_ff[adj_raddr_ff] ? adj_rdata : '0;
   assign pop_fresh = !visited_ff[stk_rdata[RAW-1:0]];
   assign push_now  = scan_ff[0] && (sp_ff < SPW'(STACK_DEPTH));
   assign emit_go   = (emit_idx_ff != len_ff) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      adj_we    = 1'b0;
      adj_waddr = node_a_ff[RAW-1:0];
      adj_wdata = adj_row | (MAX_NODES'(1) << node_b_ff[RAW-1:0]);
      adj_re    = 1'b0;
      adj_raddr = req_data.from_node[RAW-1:0];
      stk_we    = 1'b0;
      stk_waddr = sp_ff[SAW-1:0];
      stk_wdata = scan_idx_ff;
      stk_re    = 1'b0;
      stk_raddr = SAW'(sp_ff - SPW'(1));
      ord_we    = 1'b0;
      ord_re    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            adj_re = req_take && (req_data.op == gdo_pkg::OP_ADD_EDGE) && edge_ok;
         end
         ST_EDGE_A: begin
            adj_we    = 1'b1;
            adj_re    = mirror_ff;
            adj_raddr = node_b_ff[RAW-1:0];
         end
         ST_EDGE_B: begin
            adj_we    = 1'b1;
            adj_waddr = node_b_ff[RAW-1:0];
            adj_wdata = adj_row | (MAX_NODES'(1) << node_a_ff[RAW-1:0]);
         end
         ST_START: begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
         end
         ST_POP: begin
            stk_re = (sp_ff != '0);
         end
         ST_POP_WAIT: begin
            ord_we    = pop_fresh;
            adj_re    = pop_fresh;
            adj_raddr = stk_rdata[RAW-1:0];
         end
         ST_PUSH: begin
            stk_we = push_now;
         end
         ST_EMIT_RD: begin
            ord_re = emit_go;
         end
         default: begin
         end
      endcase
   end

   gdo_ram #(
      .WIDTH (MAX_NODES),
      .DEPTH (MAX_NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   gdo_ram #(
      .WIDTH (NW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   gdo_ram #(
      .WIDTH (NW),
      .DEPTH (MAX_NODES)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (len_ff[RAW-1:0]),
      .wr_data (stk_rdata),
      .rd_en   (ord_re),
      .rd_addr (emit_idx_ff[RAW-1:0]),
      .rd_data (ord_rdata)
   );

   always_ff @(posedge clock) begin
      if (adj_re) begin
         adj_raddr_ff <= adj_raddr;
      end
      if (reset) begin
         state_ff       <= ST_IDLE;
         node_count_ff  <= gdo_pkg::NODE_COUNT_RESET;
         directed_ff    <= 1'b0;
         row_valid_ff   <= '0;
         visited_ff     <= '0;
         sp_ff          <= '0;
         len_ff         <= '0;
         emit_idx_ff    <= '0;
         order_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == gdo_pkg::REG_NODE_COUNT) begin
               node_count_ff <= csr_wdata[CW-1:0];
            end else if (csr_index == gdo_pkg::REG_DIRECTED) begin
               directed_ff <= csr_wdata[0];
            end
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (adj_we) begin
            row_valid_ff[adj_waddr] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               node_a_ff <= req_data.from_node;
               node_b_ff <= req_data.to_node;
               mirror_ff <= !directed_ff;
               mask_ff   <= live_mask;
               if (req_take) begin
                  if (req_data.op == gdo_pkg::OP_RUN) begin
                     emit_idx_ff <= '0;
                     state_ff    <= order_ready_ff ? ST_EMIT_RD : ST_START;
                  end else if (edge_ok) begin
                     state_ff <= ST_EDGE_A;
                  end
               end
            end
            ST_EDGE_A: begin
               state_ff <= mirror_ff ? ST_EDGE_B : ST_IDLE;
            end
            ST_EDGE_B: begin
               state_ff <= ST_IDLE;
            end
            ST_START: begin
               visited_ff <= '0;
               len_ff     <= '0;
               sp_ff      <= SPW'(1);
               state_ff   <= ST_POP;
            end
            ST_POP: begin
               if (sp_ff == '0) begin
                  order_ready_ff <= 1'b1;
                  state_ff       <= ST_EMIT_RD;
               end else begin
                  sp_ff    <= sp_ff - SPW'(1);
                  state_ff <= ST_POP_WAIT;
               end
            end
            ST_POP_WAIT: begin
               if (pop_fresh) begin
                  visited_ff[stk_rdata[RAW-1:0]] <= 1'b1;
                  len_ff   <= len_ff + LENW'(1);
                  state_ff <= ST_ROW_WAIT;
               end else begin
                  state_ff <= ST_POP;
               end
            end
            ST_ROW_WAIT: begin
               // Only unvisited neighbours below the live node count get pushed.
               scan_ff     <= adj_row & mask_ff & ~visited_ff;
               scan_idx_ff <= '0;
               state_ff    <= ST_PUSH;
            end
            ST_PUSH: begin
               if (scan_ff == '0) begin
                  state_ff <= ST_POP;
               end else begin
                  if (push_now) begin
                     sp_ff <= sp_ff + SPW'(1);
                  end
                  scan_ff     <= scan_ff >> 1;
                  scan_idx_ff <= scan_idx_ff + NW'(1);
               end
            end
            ST_EMIT_RD: begin
               if (emit_idx_ff == len_ff) begin
                  state_ff <= ST_IDLE;
               end else if (emit_go) begin
                  state_ff <= ST_EMIT_LD;
               end
            end
            ST_EMIT_LD: begin
               // The output slot is known to be free here: the read was issued only
               // when it was empty or being taken.
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.visit_node <= ord_rdata;
               rsp_data_ff.last       <= ((emit_idx_ff + LENW'(1)) == len_ff);
               emit_idx_ff            <= emit_idx_ff + LENW'(1);
               state_ff <= ((emit_idx_ff + LENW'(1)) == len_ff) ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/gdo_ram.sv
module gdo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
